[src/mac_pkg.sv]
// ----------------------------------------------------------------------------
// mac_pkg
// Shared widths, register indexes and memory entry types for the minimum
// arborescence contraction block.
// ----------------------------------------------------------------------------
package mac_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 16384;

    localparam int NI_W  = $clog2(MAX_NODES);      // node index
    localparam int NC_W  = $clog2(MAX_NODES + 1);  // node count
    localparam int EA_W  = $clog2(MAX_EDGES);      // edge address
    localparam int EC_W  = $clog2(MAX_EDGES + 1);  // edge count
    localparam int W_W   = 32;                     // input weight
    localparam int C_W   = 48;                     // cost and total
    localparam int CFG_W = 11;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_ROOT_NODE  = 1'b1;

    typedef struct packed {
        logic [NI_W-1:0]       tail;
        logic [NI_W-1:0]       head;
        logic signed [C_W-1:0] cost;
    } t_edge;

    typedef struct packed {
        logic signed [C_W-1:0] cheap;
        logic [NI_W-1:0]       pred;
        logic [NC_W-1:0]       stamp;
        logic [NC_W-1:0]       comp;
        logic                  has;
        logic                  stmp;
        logic                  grp;
    } t_node;

    typedef struct packed {
        logic            we;
        logic [EA_W-1:0] waddr;
        t_edge           wdata;
        logic [EA_W-1:0] raddr;
    } t_edge_req;

    typedef struct packed {
        logic            we;
        logic [NI_W-1:0] waddr;
        t_node           wdata;
        logic [NI_W-1:0] raddr;
    } t_node_req;

endpackage

[src/mac_edge_store.sv]
// ----------------------------------------------------------------------------
// mac_edge_store
// Edge memory: tail, head and cost per entry, one write and one registered
// read each cycle.
// ----------------------------------------------------------------------------
module mac_edge_store import mac_pkg::*; (
    input  logic      i_clk,
    input  t_edge_req i_req,
    output t_edge     o_rdata
);

    t_edge r_mem [MAX_EDGES];
    t_edge r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/mac_node_store.sv]
// ----------------------------------------------------------------------------
// mac_node_store
// Per-node memory: pick cost, predecessor, stamp, component and flags,
// one write and one registered read each cycle.
// ----------------------------------------------------------------------------
module mac_node_store import mac_pkg::*; (
    input  logic      i_clk,
    input  t_node_req i_req,
    output t_node     o_rdata
);

    t_node r_mem [MAX_NODES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/mac_solver.sv]
// ----------------------------------------------------------------------------
// mac_solver
// Load sequencer and contraction engine: walks both memories with
// read-then-write steps and holds the result register.
// ----------------------------------------------------------------------------
module mac_solver import mac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [NC_W-1:0]       i_node_count,
    input  logic [NI_W-1:0]       i_root_node,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [NI_W-1:0]       i_edge_source,
    input  logic [NI_W-1:0]       i_edge_dest,
    input  logic signed [W_W-1:0] i_edge_weight,
    input  logic                  i_last_edge,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [C_W-1:0] o_total_weight,
    output logic                  o_found,
    output t_edge_req             o_edge_req,
    input  t_edge                 i_edge_rd,
    output t_node_req             o_node_req,
    input  t_node                 i_node_rd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FRD   = 5'd1;
    localparam logic [4:0] S_FWR   = 5'd2;
    localparam logic [4:0] S_CLR   = 5'd3;
    localparam logic [4:0] S_PRD   = 5'd4;
    localparam logic [4:0] S_PNODE = 5'd5;
    localparam logic [4:0] S_PUPD  = 5'd6;
    localparam logic [4:0] S_RRD   = 5'd7;
    localparam logic [4:0] S_RWR   = 5'd8;
    localparam logic [4:0] S_SRD   = 5'd9;
    localparam logic [4:0] S_SEV   = 5'd10;
    localparam logic [4:0] S_WRD   = 5'd11;
    localparam logic [4:0] S_WEV   = 5'd12;
    localparam logic [4:0] S_GRD   = 5'd13;
    localparam logic [4:0] S_GEV   = 5'd14;
    localparam logic [4:0] S_GJW   = 5'd15;
    localparam logic [4:0] S_ARD   = 5'd16;
    localparam logic [4:0] S_AEV   = 5'd17;
    localparam logic [4:0] S_CRD   = 5'd18;
    localparam logic [4:0] S_CT    = 5'd19;
    localparam logic [4:0] S_CH    = 5'd20;
    localparam logic [4:0] S_CW    = 5'd21;
    localparam logic [4:0] S_RTRD  = 5'd22;
    localparam logic [4:0] S_RTEV  = 5'd23;

    localparam logic [EC_W-1:0] EDGE_MAX = EC_W'(MAX_EDGES);
    localparam logic [NC_W-1:0] NODE_MAX = NC_W'(MAX_NODES);

    logic [4:0]            r_state, n_state;
    logic [EC_W-1:0]       r_loaded, n_loaded;
    logic [EC_W-1:0]       r_lim, n_lim;
    logic [EC_W-1:0]       r_e, n_e;
    logic [EC_W-1:0]       r_m, n_m;
    logic [NC_W-1:0]       r_i, n_i;
    logic [NC_W-1:0]       r_n, n_n;
    logic [NC_W-1:0]       r_comps, n_comps;
    logic [NI_W-1:0]       r_r, n_r;
    logic [NI_W-1:0]       r_j, n_j;
    logic [NI_W-1:0]       r_k, n_k;
    logic [NI_W-1:0]       r_ct, n_ct;
    t_edge                 r_edge, n_edge;
    logic signed [C_W-1:0] r_sum, n_sum;
    logic                  r_out_valid, n_out_valid;
    logic signed [C_W-1:0] r_total, n_total;
    logic                  r_found, n_found;

    logic      in_acc;
    logic      do_next;
    logic      walk_go;
    logic      bad_cfg;
    logic [NI_W-1:0] comp_h;
    t_node     nd;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign bad_cfg = (i_node_count == '0) || (i_node_count > NODE_MAX)
                     || ({1'b0, i_root_node} >= i_node_count);

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_lim       = r_lim;
        n_e         = r_e;
        n_m         = r_m;
        n_i         = r_i;
        n_n         = r_n;
        n_comps     = r_comps;
        n_r         = r_r;
        n_j         = r_j;
        n_k         = r_k;
        n_ct        = r_ct;
        n_edge      = r_edge;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_total     = r_total;
        n_found     = r_found;
        do_next     = 1'b0;
        walk_go     = 1'b0;
        comp_h      = i_node_rd.comp[NI_W-1:0];
        nd          = i_node_rd;

        o_edge_req.we    = 1'b0;
        o_edge_req.waddr = r_m[EA_W-1:0];
        o_edge_req.wdata = r_edge;
        o_edge_req.raddr = r_e[EA_W-1:0];
        o_node_req.we    = 1'b0;
        o_node_req.waddr = r_i[NI_W-1:0];
        o_node_req.wdata = i_node_rd;
        o_node_req.raddr = r_i[NI_W-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_loaded = r_loaded;
                    if (r_loaded < EDGE_MAX) begin
                        o_edge_req.we    = 1'b1;
                        o_edge_req.waddr = r_loaded[EA_W-1:0];
                        o_edge_req.wdata.tail = i_edge_source;
                        o_edge_req.wdata.head = i_edge_dest;
                        o_edge_req.wdata.cost = C_W'(i_edge_weight);
                        n_loaded = r_loaded + 1'b1;
                    end
                    if (i_last_edge) begin
                        n_lim    = n_loaded;
                        n_loaded = '0;
                        if (bad_cfg) begin
                            n_out_valid = 1'b1;
                            n_total     = '0;
                            n_found     = 1'b0;
                        end else begin
                            n_n     = i_node_count;
                            n_r     = i_root_node;
                            n_e     = '0;
                            n_m     = '0;
                            n_sum   = '0;
                            n_state = S_FRD;
                        end
                    end
                end
            end
            // drop edges with an endpoint outside the node range
            S_FRD: begin
                if (r_e == r_lim) begin
                    n_i     = '0;
                    n_state = S_CLR;
                end else begin
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                if ({1'b0, i_edge_rd.tail} < r_n && {1'b0, i_edge_rd.head} < r_n) begin
                    o_edge_req.we    = 1'b1;
                    o_edge_req.wdata = i_edge_rd;
                    n_m = r_m + 1'b1;
                end
                n_e     = r_e + 1'b1;
                n_state = S_FRD;
            end
            S_CLR: begin
                o_node_req.we    = 1'b1;
                o_node_req.wdata = '0;
                if (r_i == r_n - 1'b1) begin
                    n_e     = '0;
                    n_state = S_PRD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            // cheapest incoming edge per node
            S_PRD: begin
                n_state = (r_e == r_m) ? S_RRD : S_PNODE;
            end
            S_PNODE: begin
                n_edge = i_edge_rd;
                o_node_req.raddr = i_edge_rd.head;
                if (i_edge_rd.tail != i_edge_rd.head) begin
                    n_state = S_PUPD;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_PUPD: begin
                if (!i_node_rd.has || i_node_rd.cheap > r_edge.cost) begin
                    nd.has   = 1'b1;
                    nd.cheap = r_edge.cost;
                    nd.pred  = r_edge.tail;
                    o_node_req.we    = 1'b1;
                    o_node_req.waddr = r_edge.head;
                    o_node_req.wdata = nd;
                end
                n_e     = r_e + 1'b1;
                n_state = S_PRD;
            end
            S_RRD: begin
                o_node_req.raddr = r_r;
                n_state = S_RWR;
            end
            S_RWR: begin
                nd.has   = 1'b1;
                nd.cheap = '0;
                o_node_req.we    = 1'b1;
                o_node_req.waddr = r_r;
                o_node_req.wdata = nd;
                n_i     = '0;
                n_state = S_SRD;
            end
            // every node needs a pick; accumulate pick costs
            S_SRD: begin
                n_state = S_SEV;
            end
            S_SEV: begin
                if (!i_node_rd.has) begin
                    n_out_valid = 1'b1;
                    n_total     = '0;
                    n_found     = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_sum = r_sum + i_node_rd.cheap;
                    if (r_i == r_n - 1'b1) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_comps = '0;
                        n_state = S_WRD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SRD;
                    end
                end
            end
            // walk predecessors from node i, stamping as we go
            S_WRD: begin
                o_node_req.raddr = r_j;
                n_state = S_WEV;
            end
            S_WEV: begin
                walk_go = !(i_node_rd.stmp && i_node_rd.stamp == r_i)
                          && !i_node_rd.grp && (r_j != r_r);
                if (walk_go) begin
                    nd.stmp  = 1'b1;
                    nd.stamp = r_i;
                    o_node_req.we    = 1'b1;
                    o_node_req.waddr = r_j;
                    o_node_req.wdata = nd;
                    n_j     = i_node_rd.pred;
                    n_state = S_WRD;
                end else if (r_j != r_r && !i_node_rd.grp) begin
                    n_k     = i_node_rd.pred;
                    n_state = S_GRD;
                end else begin
                    do_next = 1'b1;
                end
            end
            // label the cycle through j as one component
            S_GRD: begin
                o_node_req.raddr = (r_k == r_j) ? r_j : r_k;
                n_state = (r_k == r_j) ? S_GJW : S_GEV;
            end
            S_GEV: begin
                nd.comp = r_comps;
                nd.grp  = 1'b1;
                o_node_req.we    = 1'b1;
                o_node_req.waddr = r_k;
                o_node_req.wdata = nd;
                n_k     = i_node_rd.pred;
                n_state = S_GRD;
            end
            S_GJW: begin
                nd.comp = r_comps;
                nd.grp  = 1'b1;
                o_node_req.we    = 1'b1;
                o_node_req.waddr = r_j;
                o_node_req.wdata = nd;
                n_comps = r_comps + 1'b1;
                do_next = 1'b1;
            end
            // nodes outside any cycle become components of their own
            S_ARD: begin
                n_state = S_AEV;
            end
            S_AEV: begin
                if (!i_node_rd.grp) begin
                    nd.comp = r_comps;
                    nd.grp  = 1'b1;
                    o_node_req.we    = 1'b1;
                    o_node_req.wdata = nd;
                    n_comps = r_comps + 1'b1;
                end
                if (r_i == r_n - 1'b1) begin
                    n_e     = '0;
                    n_state = S_CRD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ARD;
                end
            end
            // relabel endpoints, reduce costs of entering edges
            S_CRD: begin
                n_state = (r_e == r_m) ? S_RTRD : S_CT;
            end
            S_CT: begin
                n_edge = i_edge_rd;
                o_node_req.raddr = i_edge_rd.tail;
                n_state = S_CH;
            end
            S_CH: begin
                n_ct = i_node_rd.comp[NI_W-1:0];
                o_node_req.raddr = r_edge.head;
                n_state = S_CW;
            end
            S_CW: begin
                o_edge_req.we         = 1'b1;
                o_edge_req.waddr      = r_e[EA_W-1:0];
                o_edge_req.wdata.tail = r_ct;
                o_edge_req.wdata.head = comp_h;
                o_edge_req.wdata.cost = (r_ct != comp_h) ? r_edge.cost - i_node_rd.cheap
                                                         : r_edge.cost;
                n_e     = r_e + 1'b1;
                n_state = S_CRD;
            end
            S_RTRD: begin
                o_node_req.raddr = r_r;
                n_state = S_RTEV;
            end
            S_RTEV: begin
                n_r     = i_node_rd.comp[NI_W-1:0];
                n_n     = r_comps;
                n_i     = '0;
                n_state = S_CLR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_next) begin
            if (r_i == r_n - 1'b1) begin
                if (n_comps == '0) begin
                    n_out_valid = 1'b1;
                    n_total     = n_sum;
                    n_found     = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_i     = '0;
                    n_state = S_ARD;
                end
            end else begin
                n_i     = r_i + 1'b1;
                n_j     = NI_W'(r_i + 1'b1);
                n_state = S_WRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim   <= n_lim;
        r_e     <= n_e;
        r_m     <= n_m;
        r_i     <= n_i;
        r_n     <= n_n;
        r_comps <= n_comps;
        r_r     <= n_r;
        r_j     <= n_j;
        r_k     <= n_k;
        r_ct    <= n_ct;
        r_edge  <= n_edge;
        r_sum   <= n_sum;
        r_total <= n_total;
        r_found <= n_found;
    end

    assign o_in_stall     = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_total_weight = r_total;
    assign o_found        = r_found;

endmodule

[src/min_arborescence_contraction.sv]
// Edge beats are accepted one edge per cycle while idle with no result pending.
// After the last edge, the solve filters the edges, then per round clears the nodes,
// picks, checks, walks, assigns and contracts, all paced by the one-read one-write
// node and edge memories; then one result beat.
// Reset: synchronous active low; clears the sequencer, edge count and result
// valid, node_count to 1 and root_node to 0. Memories are not cleared.
// ----------------------------------------------------------------------------
// min_arborescence_contraction
// Minimum arborescence by cycle contraction over a loaded edge list.
// ----------------------------------------------------------------------------
module min_arborescence_contraction import mac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [NI_W-1:0]       i_edge_source,
    input  logic [NI_W-1:0]       i_edge_dest,
    input  logic signed [W_W-1:0] i_edge_weight,
    input  logic                  i_last_edge,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [C_W-1:0] o_total_weight,
    output logic                  o_found
);

    logic [NC_W-1:0] r_node_count;
    logic [NI_W-1:0] r_root_node;
    t_edge_req       edge_req;
    t_edge           edge_rd;
    t_node_req       node_req;
    t_node           node_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NC_W'(1);
            r_root_node  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NODE_COUNT: r_node_count <= i_cfg_data[NC_W-1:0];
                REG_ROOT_NODE:  r_root_node  <= i_cfg_data[NI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mac_edge_store u_edge_store (
        .i_clk   (i_clk),
        .i_req   (edge_req),
        .o_rdata (edge_rd)
    );

    mac_node_store u_node_store (
        .i_clk   (i_clk),
        .i_req   (node_req),
        .o_rdata (node_rd)
    );

    mac_solver u_solver (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_node_count   (r_node_count),
        .i_root_node    (r_root_node),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_edge_source  (i_edge_source),
        .i_edge_dest    (i_edge_dest),
        .i_edge_weight  (i_edge_weight),
        .i_last_edge    (i_last_edge),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_total_weight (o_total_weight),
        .o_found        (o_found),
        .o_edge_req     (edge_req),
        .i_edge_rd      (edge_rd),
        .o_node_req     (node_req),
        .i_node_rd      (node_rd)
    );

endmodule

[src/mac_checker.sv]
// ----------------------------------------------------------------------------
// mac_checker
// Port-level checks on beat ordering and result form.
// ----------------------------------------------------------------------------
module mac_checker import mac_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_last_edge,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic signed [C_W-1:0] o_total_weight,
    input logic                  o_found
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // no edge beat is taken while a result waits
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted with result pending");

    // a failed solve reports zero weight
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_total_weight == '0)
        else $error("nonzero weight on failed solve");

    // a plain edge beat never raises a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_last_edge && !o_out_valid |=> !o_out_valid)
        else $error("result without last edge");

endmodule

bind min_arborescence_contraction mac_checker u_mac_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last_edge    (i_last_edge),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_total_weight (o_total_weight),
    .o_found        (o_found)
);
